/* rtl/mstw_pkg.sv */
// ----------------------------------------------------------------------------
// mstw_pkg - shared types and constants of the multi-slot task watchdog
// Item layouts, operation and result codes, sequencer states and the
// control group passed to the slot store.
// ----------------------------------------------------------------------------
`default_nettype none

package mstw_pkg;

  // default table size and the cap on timeout results per tick
  localparam int DEF_SLOTS   = 8;
  localparam int MAX_RESULTS = 8;

  // operation codes carried by an input item
  typedef enum logic [1:0] {
    MODE_REGISTER   = 2'd0,
    MODE_CHECKIN    = 2'd1,
    MODE_UNREGISTER = 2'd2,
    MODE_TICK       = 2'd3
  } mode_t;

  // result codes carried by a result item
  typedef enum logic [2:0] {
    KIND_DONE       = 3'd0,
    KIND_REGISTERED = 3'd1,
    KIND_FULL       = 3'd2,
    KIND_TIMEOUT    = 3'd3,
    KIND_INVALID    = 3'd4
  } kind_t;

  // input item
  typedef struct packed {
    mode_t       mode;
    logic [2:0]  slot;
    logic [31:0] limit_ms;
    logic [31:0] now_ms;
  } req_t;

  // result item
  typedef struct packed {
    kind_t      result_kind;
    logic [2:0] slot_out;
    logic       last;
  } rsp_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_FIND,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // slot store controls
  typedef struct packed {
    logic rd_en;
    logic tmo_we;
    logic time_we;
    logic act_set;
    logic act_clr;
  } store_ctl_t;

endpackage

`default_nettype wire

/* rtl/mstw_store.sv */
// ----------------------------------------------------------------------------
// mstw_store - slot storage of the watchdog
// Two single-port-write memories for timeout and check-in time, with
// registered reads, plus reset-cleared active marks and their count.
// ----------------------------------------------------------------------------
`default_nettype none

module mstw_store #(
  parameter int SLOTS = mstw_pkg::DEF_SLOTS,
  parameter int IW    = 3,
  parameter int CW    = 4
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire mstw_pkg::store_ctl_t ctl,
  input  wire  [IW-1:0]         rd_idx,
  input  wire  [IW-1:0]         wr_idx,
  input  wire  [31:0]           wr_tmo,
  input  wire  [31:0]           wr_time,
  output logic [31:0]           rd_tmo,
  output logic [31:0]           rd_time,
  output logic [SLOTS-1:0]      active,
  output logic [CW-1:0]         active_count
);
  import mstw_pkg::*;

  logic [31:0] tmo_mem  [SLOTS];
  logic [31:0] time_mem [SLOTS];

  // timeout memory
  always_ff @(posedge clk) begin
    if (ctl.tmo_we) begin
      tmo_mem[wr_idx] <= wr_tmo;
    end
    if (ctl.rd_en) begin
      rd_tmo <= tmo_mem[rd_idx];
    end
  end

  // check-in time memory
  always_ff @(posedge clk) begin
    if (ctl.time_we) begin
      time_mem[wr_idx] <= wr_time;
    end
    if (ctl.rd_en) begin
      rd_time <= time_mem[rd_idx];
    end
  end

  // active marks and count of active slots
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      active_count <= '0;
    end else if (ctl.act_set) begin
      active[wr_idx] <= 1'b1;
      active_count   <= active_count + CW'(1);
    end else if (ctl.act_clr) begin
      active[wr_idx] <= 1'b0;
      active_count   <= active_count - CW'(1);
    end
  end

`ifndef NO_ASSERTIONS
  // count tracks the marks
  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(active) == int'(active_count))
    else $error("active count out of step with active marks");

  // a slot is only taken when free
  a_set_free: assert property (@(posedge clk) disable iff (rst)
    ctl.act_set |-> !active[wr_idx])
    else $error("register took an active slot");

  // a slot is only freed when taken
  a_clr_taken: assert property (@(posedge clk) disable iff (rst)
    ctl.act_clr |-> active[wr_idx])
    else $error("unregister freed an inactive slot");
`endif

endmodule

`default_nettype wire

/* rtl/multi_slot_task_watchdog.sv */
// ----------------------------------------------------------------------------
// multi_slot_task_watchdog - table of software watchdog slots
// Register, check-in, unregister and tick scan over SLOTS slots kept in
// memories; expired slots are reported one result item each.
// ----------------------------------------------------------------------------
//
//   channel | valid     | stall     | payload | carries
//   --------+-----------+-----------+---------+-------------------------------
//   request | req_valid | req_stall | req     | mode, slot, limit_ms, now_ms
//   result  | rsp_valid | rsp_stall | rsp     | result_kind, slot_out, last
//
// check-in and unregister are done in ST_OP; register walks ST_FIND past
// each occupied slot below the first free one (no walk when full).
// a tick does one memory read per slot, pipelined with the compare and
// write-back of the previous slot.
// one item is worked on at a time; req_stall is high while it is.
// synchronous reset clears the active marks; the memories are not cleared.
// a stalled result holds the sequencer only when a new result must be shown.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_slot_task_watchdog #(
  parameter int SLOTS = mstw_pkg::DEF_SLOTS
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            req_valid,
  output logic           req_stall,
  input  wire mstw_pkg::req_t req,
  output logic           rsp_valid,
  input  wire            rsp_stall,
  output mstw_pkg::rsp_t rsp
);
  import mstw_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int HW = $clog2(MAX_RESULTS + 1);

  state_t           state, state_next;
  req_t             cur;
  logic [IW-1:0]    find_idx;
  logic [CW-1:0]    scan_idx;
  logic             ev_valid;
  logic [IW-1:0]    ev_idx;
  logic             pend_valid;
  logic [2:0]       pend_slot;
  logic [HW-1:0]    hits;

  store_ctl_t       ctl;
  logic [IW-1:0]    rd_idx, wr_idx;
  logic [31:0]      wr_tmo, wr_time;
  logic [31:0]      rd_tmo, rd_time;
  logic [SLOTS-1:0] active;
  logic [CW-1:0]    active_count;

  logic             accept, can_push, push;
  rsp_t             rsp_next;
  logic [IW+2:0]    slot_wide, find_wide, ev_wide;
  logic [IW-1:0]    op_idx;
  logic             slot_ok, op_ok, full;
  logic             scan_left, issue, hit, ev_adv;
  logic [31:0]      elapsed;

  mstw_store #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .CW    (CW)
  ) u_store (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .rd_idx       (rd_idx),
    .wr_idx       (wr_idx),
    .wr_tmo       (wr_tmo),
    .wr_time      (wr_time),
    .rd_tmo       (rd_tmo),
    .rd_time      (rd_time),
    .active       (active),
    .active_count (active_count)
  );

  // handshake
  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign can_push  = !rsp_valid || !rsp_stall;

  // slot number of the held item, checked against the table size
  assign slot_wide = (IW+3)'(cur.slot);
  assign slot_ok   = slot_wide < (IW+3)'(SLOTS);
  assign op_idx    = slot_wide[IW-1:0];
  assign op_ok     = slot_ok && active[op_idx];
  assign full      = (active_count == CW'(SLOTS));
  assign find_wide = (IW+3)'(find_idx);
  assign ev_wide   = (IW+3)'(ev_idx);

  // scan pipeline: read stage and compare stage
  assign elapsed   = cur.now_ms - rd_time;
  assign hit       = ev_valid && active[ev_idx] && (elapsed >= rd_tmo)
                     && (hits < HW'(MAX_RESULTS));
  assign ev_adv    = ev_valid && (!(hit && pend_valid) || can_push);
  assign scan_left = scan_idx < CW'(SLOTS);
  assign issue     = (state == ST_SCAN) && scan_left && (!ev_valid || ev_adv);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.mode)
            MODE_REGISTER:                 state_next = ST_FIND;
            MODE_CHECKIN, MODE_UNREGISTER: state_next = ST_OP;
            MODE_TICK:                     state_next = ST_SCAN;
            default:                       state_next = ST_IDLE;
          endcase
        end
      end
      ST_OP: begin
        if (can_push) begin
          state_next = ST_IDLE;
        end
      end
      ST_FIND: begin
        if ((full || !active[find_idx]) && can_push) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!scan_left && (!ev_valid || ev_adv)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (can_push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: store controls and result pushes
  always_comb begin
    ctl      = '0;
    rd_idx   = scan_idx[IW-1:0];
    wr_idx   = find_idx;
    wr_tmo   = cur.limit_ms;
    wr_time  = cur.now_ms;
    push     = 1'b0;
    rsp_next = '{result_kind: KIND_DONE, slot_out: 3'd0, last: 1'b1};
    unique case (state)
      ST_IDLE: begin
      end
      ST_OP: begin
        wr_idx = op_idx;
        if (can_push) begin
          push        = 1'b1;
          ctl.time_we = op_ok && (cur.mode == MODE_CHECKIN);
          ctl.act_clr = op_ok && (cur.mode == MODE_UNREGISTER);
          rsp_next    = '{result_kind: op_ok ? KIND_DONE : KIND_INVALID,
                          slot_out: cur.slot, last: 1'b1};
        end
      end
      ST_FIND: begin
        if (full) begin
          push     = can_push;
          rsp_next = '{result_kind: KIND_FULL, slot_out: 3'd0, last: 1'b1};
        end else if (!active[find_idx] && can_push) begin
          push        = 1'b1;
          ctl.tmo_we  = 1'b1;
          ctl.time_we = 1'b1;
          ctl.act_set = 1'b1;
          rsp_next    = '{result_kind: KIND_REGISTERED,
                          slot_out: find_wide[2:0], last: 1'b1};
        end
      end
      ST_SCAN: begin
        ctl.rd_en = issue;
        wr_idx    = ev_idx;
        if (ev_adv && hit) begin
          ctl.time_we = 1'b1;
          push        = pend_valid;
          rsp_next    = '{result_kind: KIND_TIMEOUT, slot_out: pend_slot, last: 1'b0};
        end
      end
      ST_FINISH: begin
        push = can_push;
        if (pend_valid) begin
          rsp_next = '{result_kind: KIND_TIMEOUT, slot_out: pend_slot, last: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ev_valid   <= 1'b0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        ev_valid   <= 1'b0;
        pend_valid <= 1'b0;
      end else if (state == ST_SCAN) begin
        if (issue) begin
          ev_valid <= 1'b1;
        end else if (ev_adv) begin
          ev_valid <= 1'b0;
        end
        if (ev_adv && hit) begin
          pend_valid <= 1'b1;
        end
      end else if (state == ST_FINISH && can_push) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // item, counters and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur      <= req;
      find_idx <= '0;
      scan_idx <= '0;
      hits     <= '0;
    end else begin
      if (state == ST_FIND && !full && active[find_idx]) begin
        find_idx <= find_idx + IW'(1);
      end
      if (issue) begin
        scan_idx <= scan_idx + CW'(1);
        ev_idx   <= rd_idx;
      end
      if (state == ST_SCAN && ev_adv && hit) begin
        hits      <= hits + HW'(1);
        pend_slot <= ev_wide[2:0];
      end
    end
    if (push) begin
      rsp <= rsp_next;
    end
  end

`ifndef NO_ASSERTIONS
  // timeout count per tick stays within the cap
  a_hits_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_FINISH) |-> (hits <= HW'(MAX_RESULTS)))
    else $error("more timeouts than allowed in one tick");

  // compare stage only busy during a scan
  a_ev_scan: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> (state == ST_SCAN))
    else $error("scan compare stage busy outside a scan");

  // a held timeout only lives within a tick
  a_pend_tick: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_SCAN || state == ST_FINISH))
    else $error("pending timeout outside a tick");

  // only timeouts are followed by further items of the same request
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.result_kind == KIND_TIMEOUT))
    else $error("non-final result item that is not a timeout");
`endif

endmodule

`default_nettype wire

/* sim/mstw_checker.sv */
// ----------------------------------------------------------------------------
// mstw_checker - result checker for the multi-slot task watchdog
// Watches both channels, keeps its own copy of the slot table, works out the
// result items that each accepted request causes and compares every accepted
// result item against the oldest one still due.
// ----------------------------------------------------------------------------
module mstw_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_stall,
  input  mstw_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_stall,
  input  mstw_pkg::rsp_t rsp,
  output int             errors,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mstw_pkg::*;

  localparam int NUM_SLOTS = DEF_SLOTS;

  // own copy of the slot table
  logic [NUM_SLOTS-1:0] slot_live;
  logic [31:0]          slot_limit [NUM_SLOTS];
  logic [31:0]          slot_stamp [NUM_SLOTS];

  // result items still due, oldest first
  rsp_t due_results [$];

  function automatic rsp_t result_of(input kind_t kind, input int unsigned idx);
    rsp_t r;
    r.result_kind = kind;
    r.slot_out    = idx[2:0];
    r.last        = 1'b0;
    return r;
  endfunction

  // apply one request to the table and queue the result items it causes
  task automatic run_table_op(input req_t r);
    rsp_t        found [$];
    rsp_t        one;
    logic [31:0] elapsed;
    bit          placed;
    int          i;
    placed = 1'b0;
    case (r.mode)
      MODE_REGISTER: begin
        // lowest free slot wins
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !slot_live[i]) begin
            slot_live[i]  = 1'b1;
            slot_limit[i] = r.limit_ms;
            slot_stamp[i] = r.now_ms;
            placed        = 1'b1;
            found.push_back(result_of(KIND_REGISTERED, i));
          end
        end
        if (!placed) found.push_back(result_of(KIND_FULL, 0));
      end
      MODE_CHECKIN, MODE_UNREGISTER: begin
        // an inactive slot is refused and left alone
        if (!slot_live[r.slot]) begin
          found.push_back(result_of(KIND_INVALID, r.slot));
        end else begin
          if (r.mode == MODE_CHECKIN) slot_stamp[r.slot] = r.now_ms;
          else slot_live[r.slot] = 1'b0;
          found.push_back(result_of(KIND_DONE, r.slot));
        end
      end
      default: begin
        // tick: expired slots in index order up to MAX_RESULTS, each one's time restarted at now
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_live[i] && found.size() < MAX_RESULTS) begin
            elapsed = r.now_ms - slot_stamp[i];
            if (elapsed >= slot_limit[i]) begin
              found.push_back(result_of(KIND_TIMEOUT, i));
              slot_stamp[i] = r.now_ms;
            end
          end
        end
        if (found.size() == 0) found.push_back(result_of(KIND_DONE, 0));
      end
    endcase
    // mark the final result item of this request
    for (i = 0; i < found.size(); i++) begin
      one      = found[i];
      one.last = (i == found.size() - 1);
      due_results.push_back(one);
    end
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (due_results.size() == 0) begin
      $error("unexpected result item: result_kind %0d slot_out %0d last %0d",
             got.result_kind, got.slot_out, got.last);
      errors++;
    end else begin
      want = due_results.pop_front();
      if (got.result_kind !== want.result_kind) begin
        $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
        errors++;
      end
      if (got.slot_out !== want.slot_out) begin
        $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        errors++;
      end
    end
  endtask

  // requests are taken in before results so one edge keeps the item order
  always @(posedge clk) begin
    if (rst) begin
      slot_live = '0;
      errors    = 0;
      due_results.delete();
    end else begin
      if (req_valid && !req_stall) run_table_op(req);
      if (rsp_valid && !rsp_stall) check_result(rsp);
    end
    outstanding = due_results.size();
  end

endmodule

/* sim/multi_slot_task_watchdog_tb.sv */
// ----------------------------------------------------------------------------
// multi_slot_task_watchdog_tb - testbench top of the multi-slot task watchdog
// Drives a short directed sequence (empty and full table, refused slots,
// zero and largest timeouts, time wrapping, a tick expiring every slot) and
// then random watchdog traffic in three phases of sender and receiver idling.
// Results are checked by mstw_checker; this module only gives the verdict.
// ----------------------------------------------------------------------------
module multi_slot_task_watchdog_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mstw_pkg::*;

  localparam int HALF_PERIOD      = 5;
  localparam int RESET_CYCLES     = 6;
  localparam int RANDOM_PER_PHASE = 143;
  localparam int SETTLE_CYCLES    = 30;
  localparam int CYCLE_LIMIT      = 400_000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int fail_count;
  int results_due;
  int cycle_count;

  // idling odds in percent, changed per phase
  int sender_idle_pct;
  int receiver_stall_pct;

  // stimulus-side view of the table and of the millisecond clock
  logic [7:0]  busy_mask;
  logic [31:0] clock_ms;

  always #HALF_PERIOD clk = ~clk;

  multi_slot_task_watchdog u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  mstw_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .errors      (fail_count),
    .outstanding (results_due)
  );

  // receiver back-pressure
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** multi_slot_task_watchdog: FAILED **");
    $finish;
  end

  function automatic req_t make_item(input mode_t m, input logic [2:0] s,
                                     input logic [31:0] t, input logic [31:0] n);
    req_t it;
    it.mode     = m;
    it.slot     = s;
    it.limit_ms = t;
    it.now_ms   = n;
    return it;
  endfunction

  // a busy slot when one is wanted and there is one, otherwise any slot
  function automatic logic [2:0] pick_slot(input bit want_busy);
    logic [2:0] s;
    int         k;
    s = 3'($urandom_range(7));
    if (want_busy && busy_mask != 0) begin
      for (k = 0; k < 8; k++) if (!busy_mask[s]) s = s + 3'd1;
    end
    return s;
  endfunction

  // mostly well-formed watchdog traffic on a slowly running clock, some noise
  function automatic req_t random_item();
    req_t it;
    int   pick;
    pick = $urandom_range(99);
    clock_ms += ($urandom_range(15) == 0) ? $urandom_range(200) : $urandom_range(4);
    it = make_item(MODE_TICK, 3'($urandom), $urandom, clock_ms);
    if (pick < 10) begin
      it.mode   = mode_t'($urandom_range(3));
      it.now_ms = $urandom;
    end else if (pick < 28) begin
      it.mode     = MODE_REGISTER;
      it.limit_ms = ($urandom_range(7) == 0) ? $urandom : $urandom_range(40);
    end else if (pick < 58) begin
      it.mode = MODE_CHECKIN;
      it.slot = pick_slot($urandom_range(9) != 0);
    end else if (pick < 68) begin
      it.mode = MODE_UNREGISTER;
      it.slot = pick_slot($urandom_range(4) != 0);
    end
    return it;
  endfunction

  // hand one item over, idling before it at random
  task automatic send_item(input req_t item);
    bit placed;
    int k;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    // follow the table occupancy for later slot picks
    placed = 1'b0;
    if (item.mode == MODE_REGISTER) begin
      for (k = 0; k < 8; k++) begin
        if (!placed && !busy_mask[k]) begin
          busy_mask[k] = 1'b1;
          placed       = 1'b1;
        end
      end
    end else if (item.mode == MODE_UNREGISTER) begin
      busy_mask[item.slot] = 1'b0;
    end
  endtask

  // hold off until every result item due has come
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  initial begin
    int          k;
    int          phase;
    logic [31:0] t0;
    rst                = 1'b1;
    req_valid          = 1'b0;
    req                = '0;
    busy_mask          = '0;
    sender_idle_pct    = 15;
    receiver_stall_pct = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    receiver_stall_pct = 88;

    // directed: empty table, refused slots, fill to full, wrap, mass expiry
    t0 = 32'hFFFF_FFF0;
    send_item(make_item(MODE_TICK, 3'($urandom), $urandom, t0));
    send_item(make_item(MODE_CHECKIN, 3'd3, $urandom, t0));
    send_item(make_item(MODE_UNREGISTER, 3'd7, $urandom, t0));
    send_item(make_item(MODE_REGISTER, 3'($urandom), 32'd0, t0));
    send_item(make_item(MODE_REGISTER, 3'($urandom), 32'hFFFF_FFFF, t0));
    for (k = 2; k < 8; k++) begin
      send_item(make_item(MODE_REGISTER, 3'($urandom), 32'(8 * k), t0 + 32'(k)));
    end
    send_item(make_item(MODE_REGISTER, 3'($urandom), $urandom, t0));
    send_item(make_item(MODE_TICK, 3'($urandom), $urandom, t0 + 32'd2));
    send_item(make_item(MODE_CHECKIN, 3'd2, $urandom, 32'd3));
    send_item(make_item(MODE_TICK, 3'($urandom), $urandom, 32'd40));
    send_item(make_item(MODE_UNREGISTER, 3'd1, $urandom, 32'd40));
    send_item(make_item(MODE_UNREGISTER, 3'd1, $urandom, 32'd40));
    send_item(make_item(MODE_REGISTER, 3'($urandom), 32'd1, 32'd41));
    send_item(make_item(MODE_TICK, 3'($urandom), $urandom, 32'h8000_0040));
    send_item(make_item(MODE_TICK, 3'($urandom), $urandom, 32'h8000_0040));
    drain();

    // random traffic: slow receiver, then slow sender, then no idling
    clock_ms = 32'h8000_0040;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 15;
          receiver_stall_pct = 88;
        end
        1: begin
          sender_idle_pct    = 88;
          receiver_stall_pct = 15;
          clock_ms           = 32'hFFFF_FF80;
        end
        default: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
      endcase
      for (k = 0; k < RANDOM_PER_PHASE; k++) send_item(random_item());
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("** multi_slot_task_watchdog: PASSED **");
    end else begin
      $display("** multi_slot_task_watchdog: FAILED **");
    end
    $finish;
  end

endmodule

/* multi_slot_task_watchdog.f */
rtl/mstw_pkg.sv
rtl/mstw_store.sv
rtl/multi_slot_task_watchdog.sv
sim/mstw_checker.sv
sim/multi_slot_task_watchdog_tb.sv
